// ===== rtl/b64sd_pkg.sv =====
// Package: payload types, decode step type and character map for the base64url decoder.
`default_nettype none
package b64sd_pkg;

   localparam int unsigned SextetW    = 6;
   localparam int unsigned AccW       = 18;
   localparam int unsigned MaxResults = 3;

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharDash   = 8'h2D;
   localparam logic [7:0] CharUnder  = 8'h5F;
   localparam logic [7:0] CharPlus   = 8'h2B;
   localparam logic [7:0] CharSlash  = 8'h2F;

   localparam logic [5:0] OffsetLower = 6'd26;
   localparam logic [5:0] OffsetDigit = 6'd52;
   localparam logic [5:0] Sextet62    = 6'd62;
   localparam logic [5:0] Sextet63    = 6'd63;

   typedef struct packed {
      logic [7:0] symbol_char;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       decode_error;
      logic       last_of_message;
   } rsp_payload_type;

   typedef struct packed {
      logic                  valid;
      logic [SextetW-1:0]    value;
   } sextet_type;

   typedef struct packed {
      logic [1:0]            num_results;
      rsp_payload_type [MaxResults-1:0] results;
      logic [AccW-1:0]       acc_next;
      logic [1:0]            count_next;
      logic                  drop_next;
   } step_type;

   function automatic sextet_type char_to_sextet(input logic [7:0] c, input logic plus_slash);
      sextet_type s;
      logic [7:0] d;
      s = '{valid: 1'b0, value: '0};
      d = '0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         d = c - CharUpperA;
         s = '{valid: 1'b1, value: d[5:0]};
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         d = c - CharLowerA;
         s = '{valid: 1'b1, value: d[5:0] + OffsetLower};
      end else if (c >= CharZero && c <= CharNine) begin
         d = c - CharZero;
         s = '{valid: 1'b1, value: d[5:0] + OffsetDigit};
      end else if (c == CharDash || (plus_slash && c == CharPlus)) begin
         s = '{valid: 1'b1, value: Sextet62};
      end else if (c == CharUnder || (plus_slash && c == CharSlash)) begin
         s = '{valid: 1'b1, value: Sextet63};
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/b64sd_step.sv =====
// Combinational step: maps one character and the pending group to results and next state.
`default_nettype none
module b64sd_step (
   input  wire b64sd_pkg::req_payload_type     item,
   input  wire logic                           plus_slash,
   input  wire logic [b64sd_pkg::AccW-1:0]     acc,
   input  wire logic [1:0]                     count,
   input  wire logic                           dropping,
   output b64sd_pkg::step_type                 step
);

   localparam b64sd_pkg::rsp_payload_type ErrResult = '{
      data_byte: 8'd0, decode_error: 1'b1, last_of_message: 1'b1};

   b64sd_pkg::sextet_type       sx;
   logic [b64sd_pkg::AccW-1:0]  acc_shift;
   logic [23:0]                 word;
   logic [1:0]                  count_inc;

   always_comb begin
      sx        = b64sd_pkg::char_to_sextet(item.symbol_char, plus_slash);
      acc_shift = {acc[b64sd_pkg::AccW-b64sd_pkg::SextetW-1:0], sx.value};
      word      = {acc, sx.value};
      count_inc = count + 2'd1;

      step.num_results = 2'd0;
      step.results     = '0;
      step.acc_next    = acc;
      step.count_next  = count;
      step.drop_next   = dropping;

      if (dropping) begin
         if (item.end_of_input) begin
            step.drop_next  = 1'b0;
            step.acc_next   = '0;
            step.count_next = 2'd0;
         end
      end else if (!sx.valid) begin
         step.acc_next    = '0;
         step.count_next  = 2'd0;
         step.drop_next   = !item.end_of_input;
         step.num_results = 2'd1;
         step.results[0]  = ErrResult;
      end else if (count == 2'd3) begin
         step.acc_next    = '0;
         step.count_next  = 2'd0;
         step.num_results = 2'd3;
         step.results[0]  = '{data_byte: word[23:16], decode_error: 1'b0,
                              last_of_message: 1'b0};
         step.results[1]  = '{data_byte: word[15:8], decode_error: 1'b0,
                              last_of_message: 1'b0};
         step.results[2]  = '{data_byte: word[7:0], decode_error: 1'b0,
                              last_of_message: item.end_of_input};
      end else if (!item.end_of_input) begin
         step.acc_next   = acc_shift;
         step.count_next = count_inc;
      end else begin
         step.acc_next   = '0;
         step.count_next = 2'd0;
         case (count_inc)
            2'd1: begin
               step.num_results = 2'd1;
               step.results[0]  = ErrResult;
            end
            2'd2: begin
               step.num_results = 2'd1;
               step.results[0]  = '{data_byte: acc_shift[11:4], decode_error: 1'b0,
                                    last_of_message: 1'b1};
            end
            default: begin
               step.num_results = 2'd2;
               step.results[0]  = '{data_byte: acc_shift[17:10], decode_error: 1'b0,
                                    last_of_message: 1'b0};
               step.results[1]  = '{data_byte: acc_shift[9:2], decode_error: 1'b0,
                                    last_of_message: 1'b1};
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/base64url_stream_decoder_unit.sv =====
// Top level: unpadded base64url stream decoder with a result queue of up to three beats.
// Takes one character beat per cycle while req_ready is high. Decoding and the group
// state update happen in the cycle a character is accepted, and its results (none, one,
// two or three bytes, or a single error beat) load a three-entry result register that
// drains one beat per cycle of rsp_ready; the first result is offered the cycle after
// acceptance. A new character is taken while the last waiting result leaves, so characters
// that give no result flow at one per cycle. The csr write sets the '+' and '/' option;
// write it only while no message is in flight.
`default_nettype none
module base64url_stream_decoder_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire b64sd_pkg::req_payload_type  req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output b64sd_pkg::rsp_payload_type       rsp_payload,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_data
);

   logic                              plus_slash_ff, plus_slash_in;
   logic [b64sd_pkg::AccW-1:0]        acc_ff, acc_in;
   logic [1:0]                        count_ff, count_in;
   logic                              drop_ff, drop_in;
   b64sd_pkg::rsp_payload_type [b64sd_pkg::MaxResults-1:0] slot_ff, slot_in;
   logic [1:0]                        fill_ff, fill_in;
   b64sd_pkg::step_type               step;
   logic                              req_take, rsp_take;

   b64sd_step u_step (
      .item       (req_payload),
      .plus_slash (plus_slash_ff),
      .acc        (acc_ff),
      .count      (count_ff),
      .dropping   (drop_ff),
      .step       (step)
   );

   assign csr_ready   = 1'b1;
   assign rsp_valid   = (fill_ff != 2'd0);
   assign rsp_payload = slot_ff[0];
   assign req_ready   = (fill_ff == 2'd0) || (fill_ff == 2'd1 && rsp_ready);
   assign req_take    = req_valid && req_ready;
   assign rsp_take    = rsp_valid && rsp_ready;

   always_comb begin
      plus_slash_in = (csr_valid && csr_ready) ? csr_data : plus_slash_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      slot_in  = slot_ff;
      fill_in  = fill_ff;
      if (req_take) begin
         acc_in   = step.acc_next;
         count_in = step.count_next;
         drop_in  = step.drop_next;
         slot_in  = step.results;
         fill_in  = step.num_results;
      end else if (rsp_take) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         fill_in    = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_slash_ff <= 1'b0;
         acc_ff        <= '0;
         count_ff      <= 2'd0;
         drop_ff       <= 1'b0;
         fill_ff       <= 2'd0;
      end else begin
         plus_slash_ff <= plus_slash_in;
         acc_ff        <= acc_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

// ===== rtl/b64sd_checker.sv =====
// Port checker for the base64url decoder and its bind to the top level.
`default_nettype none
module b64sd_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire b64sd_pkg::rsp_payload_type  rsp_payload,
   input wire logic                        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.decode_error |->
         rsp_payload.data_byte == 8'd0 && rsp_payload.last_of_message)
      else $error("error beat carries data or is not last");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("character taken while results are stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_ready)
      else $error("result offered straight after reset");

endmodule

bind base64url_stream_decoder_unit b64sd_checker u_b64sd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_ready   (csr_ready)
);
`default_nettype wire
